>>> hdl/dped_pkg.sv
// shared types, constants and register codes of the double peak event detector
`timescale 1ns / 1ps

package dped_pkg;

    // payload widths
    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 32;
    localparam int CFG_BITS    = 16;
    localparam int FRAC_BITS   = 16;
    localparam int QUIET_BITS  = 17;
    localparam int EVENT_BITS  = 16;
    localparam int CFG_IDX_BITS = 8;

    // compare width that holds both a sample and a threshold, sign included
    localparam int CMP_BITS = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 1;

    // register reset values
    localparam logic [CFG_BITS-1:0] PEAK_FRACTION_RST = CFG_BITS'(58982);
    localparam logic [CFG_BITS-1:0] QUIET_DELAY_RST   = CFG_BITS'(100);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_START_THRESHOLD = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_THRESHOLD  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_FRACTION   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_QUIET_DELAY     = CFG_IDX_BITS'(3);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [QUIET_BITS-1:0] QUIET_MAX = {QUIET_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ARMED  = 3'd1,
        PH_PEAK1  = 3'd2,
        PH_VALLEY = 3'd3,
        PH_QUIET  = 3'd4
    } t_phase;

    typedef struct packed {
        logic signed [CFG_BITS-1:0] start_threshold;
        logic signed [CFG_BITS-1:0] stop_threshold;
        logic [CFG_BITS-1:0]        peak_fraction;
        logic [CFG_BITS-1:0]        quiet_delay;
    } t_cfg;

    typedef struct packed {
        t_phase                        phase;
        logic signed [SAMPLE_BITS-1:0] run_max;
        logic [INDEX_BITS-1:0]         run_max_idx;
        logic signed [SAMPLE_BITS-1:0] run_min;
        logic [INDEX_BITS-1:0]         run_min_idx;
        logic [INDEX_BITS-1:0]         sample_cnt;
        logic [QUIET_BITS-1:0]         quiet_cnt;
        logic [EVENT_BITS-1:0]         event_cnt;
        logic [INDEX_BITS-1:0]         rec_start;
        logic [INDEX_BITS-1:0]         rec_p1_idx;
        logic signed [SAMPLE_BITS-1:0] rec_p1_val;
        logic                          rec_v_ok;
        logic [INDEX_BITS-1:0]         rec_v_idx;
        logic signed [SAMPLE_BITS-1:0] rec_v_val;
        logic                          rec_p2_ok;
        logic [INDEX_BITS-1:0]         rec_p2_idx;
        logic signed [SAMPLE_BITS-1:0] rec_p2_val;
    } t_state;

    typedef struct packed {
        logic                          event_done;
        logic [INDEX_BITS-1:0]         start_index;
        logic [INDEX_BITS-1:0]         peak1_index;
        logic signed [SAMPLE_BITS-1:0] peak1_value;
        logic                          valley_valid;
        logic [INDEX_BITS-1:0]         valley_index;
        logic signed [SAMPLE_BITS-1:0] valley_value;
        logic                          peak2_valid;
        logic [INDEX_BITS-1:0]         peak2_index;
        logic signed [SAMPLE_BITS-1:0] peak2_value;
        logic [INDEX_BITS-1:0]         stop_index;
        logic [EVENT_BITS-1:0]         events_seen;
    } t_result;

endpackage

>>> hdl/dped_sample_if.sv
// sample channel: valid, ready and one signed sample
`timescale 1ns / 1ps

interface dped_sample_if;
    import dped_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/dped_result_if.sv
// result channel: valid, ready and one event record word
`timescale 1ns / 1ps

interface dped_result_if;
    import dped_pkg::*;

    logic    valid;
    logic    ready;
    t_result word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

>>> hdl/dped_cfg_if.sv
// configuration write channel: valid, ready, register index and data
`timescale 1ns / 1ps

interface dped_cfg_if;
    import dped_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/dped_step.sv
// next-state and result logic of the detector for one sample
`timescale 1ns / 1ps

module dped_step (
    input  dped_pkg::t_state                        i_state,
    input  dped_pkg::t_cfg                          i_cfg,
    input  logic signed [dped_pkg::SAMPLE_BITS-1:0] i_sample,
    output dped_pkg::t_state                        o_state,
    output dped_pkg::t_result                       o_result
);
    import dped_pkg::*;

    localparam int P1_BITS   = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int RISE_BITS = SAMPLE_BITS + FRAC_BITS + 4;

    logic signed [SAMPLE_BITS-1:0] w_run_max;
    logic [INDEX_BITS-1:0]         w_run_max_idx;
    logic signed [SAMPLE_BITS-1:0] w_run_min;
    logic [INDEX_BITS-1:0]         w_run_min_idx;

    logic signed [P1_BITS-1:0]     w_fall_lhs;
    logic signed [P1_BITS-1:0]     w_fall_rhs;
    logic                          w_fall;

    logic [FRAC_BITS:0]            w_span;
    logic signed [SAMPLE_BITS:0]   w_diff;
    logic signed [RISE_BITS-1:0]   w_diff_x3;
    logic signed [RISE_BITS-1:0]   w_rise_lhs;
    logic signed [FRAC_BITS+SAMPLE_BITS+1:0] w_rise_term;
    logic                          w_rise;

    logic signed [CMP_BITS-1:0]    w_v_cmp;
    logic signed [CMP_BITS-1:0]    w_start_cmp;
    logic signed [CMP_BITS-1:0]    w_stop_cmp;
    logic [QUIET_BITS-1:0]         w_quiet;
    logic                          w_done;

    // running extremes see the sample before the phase logic
    assign w_run_max     = (i_sample > i_state.run_max) ? i_sample : i_state.run_max;
    assign w_run_max_idx = (i_sample > i_state.run_max) ? i_state.sample_cnt
                                                        : i_state.run_max_idx;
    assign w_run_min     = (i_sample < i_state.run_min) ? i_sample : i_state.run_min;
    assign w_run_min_idx = (i_sample < i_state.run_min) ? i_state.sample_cnt
                                                        : i_state.run_min_idx;

    // first peak passed: sample * 2^16 < fraction * running max
    assign w_fall_lhs = P1_BITS'(i_sample) <<< FRAC_BITS;
    assign w_fall_rhs = P1_BITS'($signed({1'b0, i_cfg.peak_fraction})) * P1_BITS'(w_run_max);
    assign w_fall     = w_fall_lhs < w_fall_rhs;

    // second rise: 3 * 2^16 * (sample - min) > (2^16 - fraction) * peak1
    assign w_span      = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, i_cfg.peak_fraction};
    assign w_diff      = (SAMPLE_BITS+1)'(i_sample) - (SAMPLE_BITS+1)'(w_run_min);
    assign w_diff_x3   = RISE_BITS'(w_diff) + (RISE_BITS'(w_diff) <<< 1);
    assign w_rise_lhs  = w_diff_x3 <<< FRAC_BITS;
    assign w_rise_term = (FRAC_BITS+SAMPLE_BITS+2)'($signed({1'b0, w_span}))
                       * (FRAC_BITS+SAMPLE_BITS+2)'(i_state.rec_p1_val);
    assign w_rise      = w_rise_lhs > RISE_BITS'(w_rise_term);

    assign w_v_cmp     = CMP_BITS'(i_sample);
    assign w_start_cmp = CMP_BITS'(i_cfg.start_threshold);
    assign w_stop_cmp  = CMP_BITS'(i_cfg.stop_threshold);

    always_comb begin
        o_state             = i_state;
        o_state.run_max     = w_run_max;
        o_state.run_max_idx = w_run_max_idx;
        o_state.run_min     = w_run_min;
        o_state.run_min_idx = w_run_min_idx;
        w_done              = 1'b0;
        w_quiet             = i_state.quiet_cnt;

        case (i_state.phase)
            PH_ARMED: begin
                if (w_fall) begin
                    o_state.phase      = PH_PEAK1;
                    o_state.rec_p1_idx = w_run_max_idx;
                    o_state.rec_p1_val = w_run_max;
                    // min restarts from the peak value, its index is kept
                    o_state.run_min    = w_run_max;
                end
            end
            PH_PEAK1, PH_VALLEY: begin
                if (i_state.phase == PH_PEAK1 && w_rise) begin
                    o_state.phase     = PH_VALLEY;
                    o_state.run_max   = i_sample;
                    o_state.rec_v_ok  = 1'b1;
                    o_state.rec_v_idx = w_run_min_idx;
                    o_state.rec_v_val = w_run_min;
                end else if (w_v_cmp < w_stop_cmp) begin
                    if (i_state.phase == PH_VALLEY) begin
                        o_state.rec_p2_ok  = 1'b1;
                        o_state.rec_p2_idx = w_run_max_idx;
                        o_state.rec_p2_val = w_run_max;
                    end
                    o_state.phase = PH_QUIET;
                end
            end
            PH_QUIET: begin
                if (w_v_cmp > w_stop_cmp) begin
                    w_quiet = '0;
                end else if (i_state.quiet_cnt < QUIET_MAX) begin
                    w_quiet = i_state.quiet_cnt + 1'b1;
                end
                o_state.quiet_cnt = w_quiet;
                if (w_quiet > QUIET_BITS'(i_cfg.quiet_delay)) begin
                    o_state.phase     = PH_IDLE;
                    o_state.quiet_cnt = '0;
                    o_state.run_max   = '0;
                    o_state.event_cnt = i_state.event_cnt + 1'b1;
                    w_done            = 1'b1;
                end
            end
            default: begin
                // idle, and any code that is never reached
                if (w_v_cmp > w_start_cmp) begin
                    o_state.phase      = PH_ARMED;
                    o_state.rec_start  = i_state.sample_cnt;
                    o_state.rec_p1_idx = '0;
                    o_state.rec_p1_val = '0;
                    o_state.rec_v_ok   = 1'b0;
                    o_state.rec_v_idx  = '0;
                    o_state.rec_v_val  = '0;
                    o_state.rec_p2_ok  = 1'b0;
                    o_state.rec_p2_idx = '0;
                    o_state.rec_p2_val = '0;
                end else begin
                    o_state.phase = PH_IDLE;
                end
            end
        endcase

        o_state.sample_cnt = i_state.sample_cnt + 1'b1;

        o_result             = '0;
        o_result.events_seen = o_state.event_cnt;
        if (w_done) begin
            o_result.event_done  = 1'b1;
            o_result.start_index = i_state.rec_start;
            o_result.peak1_index = i_state.rec_p1_idx;
            o_result.peak1_value = i_state.rec_p1_val;
            o_result.stop_index  = i_state.sample_cnt;
            if (i_state.rec_v_ok) begin
                o_result.valley_valid = 1'b1;
                o_result.valley_index = i_state.rec_v_idx;
                o_result.valley_value = i_state.rec_v_val;
            end
            if (i_state.rec_p2_ok) begin
                o_result.peak2_valid = 1'b1;
                o_result.peak2_index = i_state.rec_p2_idx;
                o_result.peak2_value = i_state.rec_p2_val;
            end
        end
    end

endmodule

>>> hdl/double_peak_event_detector_unit.sv
// top level of the double peak event detector
`timescale 1ns / 1ps

// double peak event detector
// channels:
//   i_sample  sink, one signed sample per word
//   o_result  source, one event record word for every sample taken
//   i_cfg     sink, register writes (0 start threshold, 1 stop threshold,
//             2 peak fraction q0.16, 3 quiet delay), always ready,
//             unknown indexes are dropped
// pipeline: input register -> detector step logic -> result register
// order: an accepted sample waits in the input register, then passes the step
//   logic into the result register once that register is free
// throughput: one sample per cycle while results are taken; the state loop
//   closes through the step logic (17x16 and 18x16 multiplies in parallel)
// receiver stall: the result register holds its word, the input register
//   takes one more sample only if it is empty, and i_sample.ready stays low
//   while it holds a word until the result is taken
// reset: synchronous active low; detector goes idle, running max 0,
//   running min to the most positive sample, counters and record cleared,
//   registers back to thresholds 0, fraction 58982 and quiet delay 100
// configuration is expected only while no sample is in flight

module double_peak_event_detector_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dped_sample_if.sink           i_sample,
    dped_result_if.source         o_result,
    dped_cfg_if.sink              i_cfg
);
    import dped_pkg::*;

    // input register
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    // detector state and registers
    t_state r_state;
    t_state n_state;
    t_state w_state_rst;
    t_cfg   r_cfg;

    // result register
    logic    r_out_valid;
    t_result r_result;
    t_result w_result;

    logic w_out_free;
    logic w_fire;
    logic w_in_take;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign w_in_take  = i_sample.valid && i_sample.ready;

    assign i_sample.ready = !r_in_valid || w_fire;
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.word  = r_result;

    dped_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_sample (r_sample),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // detector state after reset: idle, min at the most positive sample
    always_comb begin
        w_state_rst         = '0;
        w_state_rst.phase   = PH_IDLE;
        w_state_rst.run_min = SAMPLE_MAX;
    end

    // input word holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
        if (w_in_take) begin
            r_sample <= i_sample.sample;
        end
    end

    // detector state advances once per processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= w_state_rst;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // result register, payload loads only with a new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_threshold <= '0;
            r_cfg.stop_threshold  <= '0;
            r_cfg.peak_fraction   <= PEAK_FRACTION_RST;
            r_cfg.quiet_delay     <= QUIET_DELAY_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_START_THRESHOLD: r_cfg.start_threshold <= i_cfg.data;
                REG_STOP_THRESHOLD:  r_cfg.stop_threshold  <= i_cfg.data;
                REG_PEAK_FRACTION:   r_cfg.peak_fraction   <= i_cfg.data;
                REG_QUIET_DELAY:     r_cfg.quiet_delay     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // a processed sample always lands in the result register
    a_fire_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed word did not reach result register");

    // detector state only moves when a sample is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_state))
        else $error("detector state changed without a sample");

    // an event can only complete from the quiet phase
    a_done_from_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_result.event_done) |-> (r_state.phase == PH_QUIET))
        else $error("event completed outside quiet phase");

    // sample index advances by one per processed sample
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_state.sample_cnt == INDEX_BITS'($past(r_state.sample_cnt) + 1'b1)))
        else $error("sample index did not advance by one");

    // a held input word is not dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> r_in_valid)
        else $error("held input word lost");

endmodule
